// ----- hdl/twcr_pkg.sv -----
// shared constants, codes and types of the textured wall column renderer
package twcr_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int MAX_ROWS      = 2048;
    localparam int MAX_TEXTURE   = 1024;

    localparam int ROW_W     = 11;
    localparam int TSZ_W     = 11;
    localparam int TEX_W     = 10;
    localparam int COL_W     = 12;
    localparam int MAP_W     = 10;
    localparam int POS_W     = 26;
    localparam int DIR_W     = 22;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int KIND_W    = 2;

    // texture period in fixed point and values kept below it
    localparam int M_W   = TSZ_W + FRACTION_BITS;
    localparam int TPOS_W = M_W - 1;

    localparam int DIV_W     = 54;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic CMD_SETUP = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_CEILING = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WALL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLOOR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR    = 3'd4;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- hdl/twcr_ifs.sv -----
// channel interfaces: configuration writes, setup/row words in, pixel words out
interface twcr_cfg_if import twcr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface twcr_in_if import twcr_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic                    hit_face;
    logic [MAP_W-1:0]        map_x;
    logic [MAP_W-1:0]        map_y;
    logic [POS_W-1:0]        player_x;
    logic [POS_W-1:0]        player_y;
    logic signed [DIR_W-1:0] ray_dir_x;
    logic signed [DIR_W-1:0] ray_dir_y;
    logic                    step_x_negative;
    logic                    step_y_negative;
    logic [COL_W-1:0]        screen_column;

    modport source (output valid, command, hit_face, map_x, map_y, player_x, player_y,
                    ray_dir_x, ray_dir_y, step_x_negative, step_y_negative, screen_column,
                    input ready);
    modport sink (input valid, command, hit_face, map_x, map_y, player_x, player_y,
                  ray_dir_x, ray_dir_y, step_x_negative, step_y_negative, screen_column,
                  output ready);
endinterface

interface twcr_out_if import twcr_pkg::*;;
    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   out_row;
    logic [KIND_W-1:0]  pixel_kind;
    logic [TEX_W-1:0]   texel_x;
    logic [TEX_W-1:0]   texel_y;
    logic [COLOR_W-1:0] flat_color;
    logic               last_row;

    modport source (output valid, out_column, out_row, pixel_kind, texel_x, texel_y,
                    flat_color, last_row, input ready);
    modport sink (input valid, out_column, out_row, pixel_kind, texel_x, texel_y,
                  flat_color, last_row, output ready);
endinterface

// ----- hdl/textured_wall_column_renderer.sv -----
// textured wall column renderer: column setup sequencer and row pixel stage
//
//  channel  dir  word                                      taken when
//  i_cfg    in   register index, write data                valid & ready (ready always)
//  i_in     in   setup (command 0) or next row (command 1)  valid & ready
//  o_out    out  one pixel of the held column               valid & ready
//
//  for a row word the pixel sits in an output register
//  a setup word runs five passes of the shared divider
//  (distance, line height, texel step, offset and position reductions) plus the span,
//  multiply and texel column steps, fewer passes when a division is skipped
//  the first wall row after a texture height write first runs
//  two divider passes that re-reduce position and step
//  i_in.ready drops while the sequencer runs or a pixel waits to be taken
//  synchronous active-low reset restores the register defaults and an empty column
module textured_wall_column_renderer import twcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twcr_cfg_if.sink   i_cfg,
    twcr_in_if.sink    i_in,
    twcr_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE, S_DIST_GO, S_DIST_WAIT, S_LH_GO, S_LH_WAIT, S_SPAN,
        S_STEP_GO, S_STEP_WAIT, S_OFF_GO, S_OFF_WAIT, S_MUL, S_POS_GO, S_POS_WAIT,
        S_TEX, S_FIX_POS_GO, S_FIX_POS_WAIT, S_FIX_STEP_GO, S_FIX_STEP_WAIT, S_EMIT
    } t_state;

    t_state r_state;

    logic [ROW_W-1:0]   r_screen_height;
    logic [TSZ_W-1:0]   r_texture_width;
    logic [TSZ_W-1:0]   r_texture_height;
    logic [COLOR_W-1:0] r_ceiling_color;
    logic [COLOR_W-1:0] r_floor_color;
    logic               r_th_dirty;

    logic [M_W-1:0]          r_anum;
    logic [DIR_W-1:0]        r_ard;
    logic signed [DIR_W-1:0] r_other_rd;
    logic [FRACTION_BITS-1:0] r_base_lo;
    logic                    r_mirror;
    logic [DVS_W-1:0]        r_dist;
    logic [DVS_W-1:0]        r_lh;
    logic [DVS_W-2:0]        r_offset;
    logic [FRACTION_BITS-1:0] r_hit_mid;
    logic [TPOS_W-1:0]       r_offm;
    logic [DIV_W-1:0]        r_prod;

    logic [ROW_W-1:0]  r_span_start;
    logic [ROW_W-1:0]  r_span_end;
    logic [ROW_W-1:0]  r_row;
    logic [TEX_W-1:0]  r_tex_col;
    logic [TPOS_W-1:0] r_pos;
    logic [TPOS_W-1:0] r_step;
    logic [TPOS_W-1:0] r_step_mod;
    logic [COL_W-1:0]  r_held;

    logic               r_out_valid;
    logic [COL_W-1:0]   r_out_column;
    logic [ROW_W-1:0]   r_out_row;
    logic [KIND_W-1:0]  r_out_kind;
    logic [TEX_W-1:0]   r_out_tx;
    logic [TEX_W-1:0]   r_out_ty;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    t_div_req div_req;
    t_div_rsp div_rsp;

    twcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // effective sizes
    logic [ROW_W-1:0] h_eff;
    logic [TSZ_W-1:0] tw_eff;
    logic [TSZ_W-1:0] th_eff;
    logic [M_W-1:0]   m_mod;

    always_comb begin
        h_eff  = (r_screen_height > ROW_W'(MAX_ROWS - 1)) ? ROW_W'(MAX_ROWS - 1)
                                                          : r_screen_height;
        tw_eff = (r_texture_width > TSZ_W'(MAX_TEXTURE)) ? TSZ_W'(MAX_TEXTURE)
                                                         : r_texture_width;
        th_eff = (r_texture_height > TSZ_W'(MAX_TEXTURE)) ? TSZ_W'(MAX_TEXTURE)
                                                          : r_texture_height;
        m_mod  = {th_eff, {FRACTION_BITS{1'b0}}};
    end

    // setup word decode
    logic                    in_take;
    logic [MAP_W:0]          cell_sum;
    logic [POS_W-1:0]        player_sel;
    logic signed [M_W:0]     num;
    logic [M_W-1:0]          anum;
    logic signed [DIR_W-1:0] rd_sel;
    logic [DIR_W-1:0]        ard;

    always_comb begin
        in_take = i_in.valid && i_in.ready;
        if (i_in.hit_face == 1'b0) begin
            cell_sum   = {1'b0, i_in.map_x} + (MAP_W + 1)'(i_in.step_x_negative);
            player_sel = i_in.player_x;
            rd_sel     = i_in.ray_dir_x;
        end else begin
            cell_sum   = {1'b0, i_in.map_y} + (MAP_W + 1)'(i_in.step_y_negative);
            player_sel = i_in.player_y;
            rd_sel     = i_in.ray_dir_y;
        end
        num  = $signed({1'b0, cell_sum, {FRACTION_BITS{1'b0}}})
             - $signed({{(M_W + 1 - POS_W){1'b0}}, player_sel});
        anum = num[M_W] ? M_W'(-num) : num[M_W-1:0];
        ard  = rd_sel[DIR_W-1] ? DIR_W'(-rd_sel) : rd_sel;
    end

    // span and hit arithmetic
    logic [ROW_W-2:0]        hh;
    logic [DVS_W-2:0]        hl;
    logic [ROW_W-1:0]        span_start;
    logic [ROW_W-1:0]        span_end;
    logic [DVS_W-1:0]        end_sum;
    logic [ROW_W-1:0]        h_m1;
    logic [DVS_W-2:0]        offset;
    logic signed [DVS_W+DIR_W:0] hit_prod;
    logic [FRACTION_BITS-1:0] frac;
    logic [FRACTION_BITS+TSZ_W-1:0] tex_prod;
    logic [TSZ_W-1:0]        tx_raw;
    logic [TSZ_W-1:0]        tx_col;
    logic [2*TPOS_W-1:0]     off_prod;

    always_comb begin
        hh       = h_eff[ROW_W-1:1];
        hl       = r_lh[DVS_W-1:1];
        span_start = ((DVS_W - 1)'(hh) > hl) ? ROW_W'((DVS_W - 1)'(hh) - hl) : '0;
        end_sum  = DVS_W'(hh) + DVS_W'(hl);
        h_m1     = h_eff - 1'b1;
        if (h_eff == '0) begin
            span_end = '0;
        end else if (end_sum > DVS_W'(h_m1)) begin
            span_end = h_m1;
        end else begin
            span_end = end_sum[ROW_W-1:0];
        end
        offset   = (hl > (DVS_W - 1)'(hh)) ? hl - (DVS_W - 1)'(hh) : '0;
        hit_prod = $signed({1'b0, r_dist}) * r_other_rd;
        frac     = r_base_lo + r_hit_mid;
        tex_prod = frac * tw_eff;
        tx_raw   = tex_prod[FRACTION_BITS +: TSZ_W];
        tx_col   = (r_mirror && tw_eff != '0) ? tw_eff - 1'b1 - tx_raw : tx_raw;
        off_prod = r_offm * r_step;
    end

    // row classification
    logic              row_ok;
    logic              row_wall;
    logic              row_ceiling;
    logic              need_fix;
    logic              do_emit;
    logic [M_W-1:0]    pos_sum;
    logic [TPOS_W-1:0] pos_next;

    always_comb begin
        row_ok      = r_row < h_eff;
        row_ceiling = r_row < r_span_start;
        row_wall    = !row_ceiling && (r_row < r_span_end);
        need_fix    = row_ok && row_wall && (m_mod != '0) && r_th_dirty;
        do_emit     = (r_state == S_IDLE && in_take && i_in.command == CMD_ROW
                       && row_ok && !need_fix) || (r_state == S_EMIT);
        pos_sum     = M_W'(r_pos) + M_W'(r_step_mod);
        pos_next    = (pos_sum >= m_mod) ? TPOS_W'(pos_sum - m_mod) : pos_sum[TPOS_W-1:0];
    end

    // divider requests
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_DIST_GO: begin
                div_req.start    = r_ard != '0;
                div_req.dividend = DIV_W'({r_anum, {FRACTION_BITS{1'b0}}});
                div_req.divisor  = DVS_W'(r_ard);
            end
            S_LH_GO: begin
                div_req.start    = r_dist != '0;
                div_req.dividend = DIV_W'({h_eff, {FRACTION_BITS{1'b0}}});
                div_req.divisor  = r_dist;
            end
            S_STEP_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(m_mod);
                div_req.divisor  = r_lh;
            end
            S_OFF_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_offset);
                div_req.divisor  = DVS_W'(m_mod);
            end
            S_POS_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = DVS_W'(m_mod);
            end
            S_FIX_POS_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_pos);
                div_req.divisor  = DVS_W'(m_mod);
            end
            S_FIX_STEP_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(r_step);
                div_req.divisor  = DVS_W'(m_mod);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_screen_height  <= ROW_W'(480);
            r_texture_width  <= TSZ_W'(64);
            r_texture_height <= TSZ_W'(64);
            r_ceiling_color  <= '0;
            r_floor_color    <= '0;
            r_th_dirty       <= 1'b0;
            r_span_start     <= '0;
            r_span_end       <= '0;
            r_row            <= '0;
            r_tex_col        <= '0;
            r_pos            <= '0;
            r_step           <= '0;
            r_step_mod       <= '0;
            r_held           <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (o_out.ready && !do_emit) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (i_in.command == CMD_SETUP) begin
                            r_anum     <= anum;
                            r_ard      <= ard;
                            r_other_rd <= i_in.hit_face ? i_in.ray_dir_x : i_in.ray_dir_y;
                            r_base_lo  <= i_in.hit_face ? i_in.player_x[FRACTION_BITS-1:0]
                                                        : i_in.player_y[FRACTION_BITS-1:0];
                            r_mirror   <= i_in.hit_face
                                ? i_in.ray_dir_y[DIR_W-1]
                                : (!i_in.ray_dir_x[DIR_W-1] && i_in.ray_dir_x != '0);
                            r_held     <= i_in.screen_column;
                            r_state    <= S_DIST_GO;
                        end else if (need_fix) begin
                            r_state <= S_FIX_POS_GO;
                        end
                    end
                end
                S_DIST_GO: begin
                    if (r_ard == '0) begin
                        r_dist  <= '1;
                        r_state <= S_LH_GO;
                    end else begin
                        r_state <= S_DIST_WAIT;
                    end
                end
                S_DIST_WAIT: begin
                    if (div_rsp.done) begin
                        r_dist  <= (div_rsp.quotient[DIV_W-1:DVS_W] != '0)
                                   ? '1 : div_rsp.quotient[DVS_W-1:0];
                        r_state <= S_LH_GO;
                    end
                end
                S_LH_GO: begin
                    if (r_dist == '0) begin
                        r_lh    <= '1;
                        r_state <= S_SPAN;
                    end else begin
                        r_state <= S_LH_WAIT;
                    end
                end
                S_LH_WAIT: begin
                    if (div_rsp.done) begin
                        r_lh    <= div_rsp.quotient[DVS_W-1:0];
                        r_state <= S_SPAN;
                    end
                end
                S_SPAN: begin
                    r_span_start <= span_start;
                    r_span_end   <= span_end;
                    r_offset     <= offset;
                    r_hit_mid    <= hit_prod[DVS_W-1:FRACTION_BITS];
                    if (m_mod == '0 || r_lh == '0) begin
                        r_step     <= '0;
                        r_step_mod <= '0;
                        r_pos      <= '0;
                        r_state    <= S_TEX;
                    end else begin
                        r_state <= S_STEP_GO;
                    end
                end
                S_STEP_GO: r_state <= S_STEP_WAIT;
                S_STEP_WAIT: begin
                    if (div_rsp.done) begin
                        r_step  <= (div_rsp.quotient[M_W-1:0] == m_mod)
                                   ? '0 : div_rsp.quotient[TPOS_W-1:0];
                        r_state <= S_OFF_GO;
                    end
                end
                S_OFF_GO: r_state <= S_OFF_WAIT;
                S_OFF_WAIT: begin
                    if (div_rsp.done) begin
                        r_offm  <= div_rsp.remainder[TPOS_W-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= DIV_W'(off_prod);
                    r_state <= S_POS_GO;
                end
                S_POS_GO: r_state <= S_POS_WAIT;
                S_POS_WAIT: begin
                    if (div_rsp.done) begin
                        r_pos      <= div_rsp.remainder[TPOS_W-1:0];
                        r_step_mod <= r_step;
                        r_state    <= S_TEX;
                    end
                end
                S_TEX: begin
                    r_tex_col  <= tx_col[TEX_W-1:0];
                    r_row      <= '0;
                    r_th_dirty <= 1'b0;
                    r_state    <= S_IDLE;
                end
                S_FIX_POS_GO: r_state <= S_FIX_POS_WAIT;
                S_FIX_POS_WAIT: begin
                    if (div_rsp.done) begin
                        r_pos   <= div_rsp.remainder[TPOS_W-1:0];
                        r_state <= S_FIX_STEP_GO;
                    end
                end
                S_FIX_STEP_GO: r_state <= S_FIX_STEP_WAIT;
                S_FIX_STEP_WAIT: begin
                    if (div_rsp.done) begin
                        r_step_mod <= div_rsp.remainder[TPOS_W-1:0];
                        r_th_dirty <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_EMIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase

            if (do_emit) begin
                r_out_valid  <= 1'b1;
                r_out_column <= r_held;
                r_out_row    <= r_row;
                r_out_last   <= r_row == h_m1;
                r_row        <= r_row + 1'b1;
                if (row_ceiling) begin
                    r_out_kind  <= KIND_CEILING;
                    r_out_tx    <= '0;
                    r_out_ty    <= '0;
                    r_out_color <= r_ceiling_color;
                end else if (row_wall) begin
                    r_out_kind  <= KIND_WALL;
                    r_out_tx    <= r_tex_col;
                    r_out_color <= '0;
                    if (m_mod != '0) begin
                        r_out_ty <= r_pos[FRACTION_BITS +: TEX_W];
                        r_pos    <= pos_next;
                    end else begin
                        r_out_ty <= '0;
                    end
                end else begin
                    r_out_kind  <= KIND_FLOOR;
                    r_out_tx    <= '0;
                    r_out_ty    <= '0;
                    r_out_color <= r_floor_color;
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_SCREEN_HEIGHT:  r_screen_height <= i_cfg.data[ROW_W-1:0];
                    REG_TEXTURE_WIDTH:  r_texture_width <= i_cfg.data[TSZ_W-1:0];
                    REG_TEXTURE_HEIGHT: begin
                        r_texture_height <= i_cfg.data[TSZ_W-1:0];
                        r_th_dirty       <= 1'b1;
                    end
                    REG_CEILING_COLOR:  r_ceiling_color <= i_cfg.data[COLOR_W-1:0];
                    REG_FLOOR_COLOR:    r_floor_color   <= i_cfg.data[COLOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);

    assign o_out.valid      = r_out_valid;
    assign o_out.out_column = r_out_column;
    assign o_out.out_row    = r_out_row;
    assign o_out.pixel_kind = r_out_kind;
    assign o_out.texel_x    = r_out_tx;
    assign o_out.texel_y    = r_out_ty;
    assign o_out.flat_color = r_out_color;
    assign o_out.last_row   = r_out_last;

endmodule

// ----- hdl/twcr_div.sv -----
// shared restoring divider, one quotient bit per cycle
module twcr_div import twcr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           ge;
    logic           last_bit;

    always_comb begin
        shifted  = {r_rem, r_quo[DIV_W-1]};
        diff     = shifted - {1'b0, r_dvs};
        ge       = shifted >= {1'b0, r_dvs};
        last_bit = r_cnt == DIV_CNT_W'(DIV_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + 1'b1;
                r_busy <= !last_bit;
                r_done <= last_bit;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- hdl/twcr_checker.sv -----
// port-level checks of the textured wall column renderer
module twcr_checker import twcr_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_in_command,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [KIND_W-1:0]  i_out_kind,
    input logic [TEX_W-1:0]   i_out_tx,
    input logic [TEX_W-1:0]   i_out_ty,
    input logic [COLOR_W-1:0] i_out_color
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("pixel word dropped while stalled");

    a_flat_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_WALL |-> i_out_tx == '0 && i_out_ty == '0)
        else $error("texel set on flat pixel");

    a_wall_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_WALL |-> i_out_color == '0)
        else $error("color set on wall pixel");

    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_command == CMD_SETUP |=> !i_in_ready)
        else $error("ready during column setup");

endmodule

bind textured_wall_column_renderer twcr_checker u_twcr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_kind   (o_out.pixel_kind),
    .i_out_tx     (o_out.texel_x),
    .i_out_ty     (o_out.texel_y),
    .i_out_color  (o_out.flat_color)
);
